// File: hw/rtl/cpss_pkg.sv
// Types, widths and helper functions shared by the segment closest-point pipeline.
`default_nettype none
package cpss_pkg;

  localparam int CW    = 24;          // coordinate width
  localparam int DIF   = CW + 1;      // coordinate difference
  localparam int PRD   = 2 * DIF;     // one product of differences
  localparam int DOT   = PRD + 2;     // sum of three products
  localparam int HALF  = DOT / 2;     // split point for wide products
  localparam int PPW   = 2 * HALF + 2;
  localparam int WIDE  = 2 * DOT;     // a*e, b*b, b*f, c*e
  localparam int MID   = 72;          // second quotient operands
  localparam int QW    = 16;          // parameter fraction bits
  localparam int PRW   = QW + 1;
  localparam int ALW   = DIF + PRW + 1;
  localparam int NW    = CW + 2;      // near point before truncation
  localparam int DFW   = NW + 1;
  localparam int SQW   = 2 * DFW;
  localparam int SUMW  = SQW + 2;
  localparam int DISTW = 52;
  localparam int THRW  = 16;
  localparam int AW    = 3;           // configuration byte address

  localparam logic REG_THR = 1'b0;    // word index of the threshold register
  localparam logic [THRW-1:0] THR_RESET = 16'd16;

  typedef logic signed [CW-1:0]   crd_t;
  typedef logic signed [DIF-1:0]  dif_t;
  typedef logic signed [PRD-1:0]  prd_t;
  typedef logic signed [DOT-1:0]  dot_t;
  typedef logic signed [WIDE-1:0] wide_t;
  typedef logic signed [MID-1:0]  mid_t;
  typedef logic signed [ALW-1:0]  alw_t;
  typedef logic signed [NW-1:0]   nw_t;
  typedef logic signed [DFW-1:0]  dfw_t;
  typedef logic signed [SQW-1:0]  sq_t;
  typedef logic [SUMW-1:0]        sum_t;
  typedef logic [PRW-1:0]         prm_t;

  localparam prm_t ONE = prm_t'(1 << QW);
  localparam logic [DISTW-1:0] DMAX = {DISTW{1'b1}};

  typedef struct packed {
    crd_t seg_a_start_x;
    crd_t seg_a_start_y;
    crd_t seg_a_start_z;
    crd_t seg_a_end_x;
    crd_t seg_a_end_y;
    crd_t seg_a_end_z;
    crd_t seg_b_start_x;
    crd_t seg_b_start_y;
    crd_t seg_b_start_z;
    crd_t seg_b_end_x;
    crd_t seg_b_end_y;
    crd_t seg_b_end_z;
  } in_t;

  typedef struct packed {
    prm_t              param_a;
    prm_t              param_b;
    crd_t              near_a_x;
    crd_t              near_a_y;
    crd_t              near_a_z;
    crd_t              near_b_x;
    crd_t              near_b_y;
    crd_t              near_b_z;
    logic [DISTW-1:0]  dist_sq;
  } out_t;

  typedef struct packed {
    crd_t [2:0] pa;
    crd_t [2:0] pb;
    dif_t [2:0] da;
    dif_t [2:0] db;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t e;
    dot_t b;
    dot_t c;
    dot_t f;
  } dots_t;

  // rides along the first divider
  typedef struct packed {
    dots_t d;
    logic  a_deg;
    logic  e_deg;
    geo_t  g;
  } d1p_t;

  // rides along the second divider; fixed goes to the parameter not divided
  typedef struct packed {
    prm_t fixed;
    logic to_t;
    geo_t g;
  } d2p_t;

  typedef struct packed {
    logic signed [PPW-1:0] hh;
    logic signed [PPW-1:0] hl;
    logic signed [PPW-1:0] lh;
    logic signed [PPW-1:0] ll;
  } pp_t;

  // Four partial products of a wide signed multiply.
  function automatic pp_t pp_mul(input dot_t x, input dot_t y);
    pp_t p;
    logic signed [HALF-1:0] xh, yh;
    logic signed [HALF:0]   xl, yl;
    xh = x[DOT-1:HALF];
    yh = y[DOT-1:HALF];
    xl = {1'b0, x[HALF-1:0]};
    yl = {1'b0, y[HALF-1:0]};
    p.hh = PPW'(xh) * PPW'(yh);
    p.hl = PPW'(xh) * PPW'(yl);
    p.lh = PPW'(xl) * PPW'(yh);
    p.ll = PPW'(xl) * PPW'(yl);
    return p;
  endfunction

  function automatic wide_t pp_sum(input pp_t p);
    return (wide_t'(p.hh) <<< (2 * HALF)) + ((wide_t'(p.hl) + wide_t'(p.lh)) <<< HALF)
           + wide_t'(p.ll);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cpss_div.sv
// Pipelined saturating fraction divider: one quotient bit per stage.
`default_nettype none
module cpss_div #(
  parameter int W  = 72,
  parameter int PW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic signed [W-1:0] num,
  input  wire logic signed [W-1:0] den,
  input  wire logic [PW-1:0]       pay_in,
  output logic                     out_vld,
  output cpss_pkg::prm_t           quo,
  output logic [PW-1:0]            pay_out
);

  localparam int QW = cpss_pkg::QW;

  logic [QW:0]             vld_r;
  logic [QW:0]             zero_r;
  logic [QW:0]             one_r;
  logic [QW:0][W-2:0]      rem_r;
  logic [QW:0][W-2:0]      d_r;
  logic [QW:0][QW-1:0]     q_r;
  logic [QW:0][PW-1:0]     pay_r;

  // entry stage: decide saturation, load magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (den <= 0) || (num <= 0);
      one_r[0]  <= num >= den;
      rem_r[0]  <= num[W-2:0];
      d_r[0]    <= den[W-2:0];
      q_r[0]    <= '0;
      pay_r[0]  <= pay_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [W-1:0] rem2;
    logic [W-1:0] diff;
    logic         ge;

    always_comb begin
      rem2 = {rem_r[k-1], 1'b0};
      diff = rem2 - {1'b0, d_r[k-1]};
      ge   = rem2 >= {1'b0, d_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        rem_r[k]  <= ge ? diff[W-2:0] : rem2[W-2:0];
        d_r[k]    <= d_r[k-1];
        q_r[k]    <= {q_r[k-1][QW-2:0], ge};
        pay_r[k]  <= pay_r[k-1];
      end
    end
  end

  always_comb begin
    out_vld = vld_r[QW];
    pay_out = pay_r[QW];
    if (zero_r[QW]) begin
      quo = '0;
    end else if (one_r[QW]) begin
      quo = cpss_pkg::ONE;
    end else begin
      quo = {1'b0, q_r[QW]};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/closest_points_segment_segment_core.sv
// Top level: closest points and squared distance between two 3D segments.
// Takes one segment pair per clock while the output is not stalled, and returns one result
// per pair. The pipeline has six stages of dot products and wide products,
// a 17-stage fraction divider for the unclamped s, one stage for the t numerator,
// a second 17-stage divider for the clamped or recomputed parameter, and four
// stages for the near points and the distance. When a result is stalled at the
// output the whole pipeline holds, and input requests are stalled with it.
`default_nettype none
module closest_points_segment_segment_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire cpss_pkg::in_t           in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output cpss_pkg::out_t               out_data,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [cpss_pkg::AW-1:0] cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int QW = cpss_pkg::QW;

  logic en;
  logic [cpss_pkg::THRW-1:0] thr_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == cpss_pkg::REG_THR) ? 32'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= cpss_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == cpss_pkg::REG_THR) begin
      thr_r <= cfg_pwdata[cpss_pkg::THRW-1:0];
    end
  end

  logic out_valid_r;
  cpss_pkg::out_t out_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: differences
  logic v1_r;
  cpss_pkg::geo_t g1_r, g1_nxt;
  cpss_pkg::dif_t [2:0] rr1_r, rr1_nxt;

  always_comb begin
    g1_nxt.pa = {in_data.seg_a_start_z, in_data.seg_a_start_y, in_data.seg_a_start_x};
    g1_nxt.pb = {in_data.seg_b_start_z, in_data.seg_b_start_y, in_data.seg_b_start_x};
    g1_nxt.da[0] = cpss_pkg::dif_t'(in_data.seg_a_end_x) - cpss_pkg::dif_t'(in_data.seg_a_start_x);
    g1_nxt.da[1] = cpss_pkg::dif_t'(in_data.seg_a_end_y) - cpss_pkg::dif_t'(in_data.seg_a_start_y);
    g1_nxt.da[2] = cpss_pkg::dif_t'(in_data.seg_a_end_z) - cpss_pkg::dif_t'(in_data.seg_a_start_z);
    g1_nxt.db[0] = cpss_pkg::dif_t'(in_data.seg_b_end_x) - cpss_pkg::dif_t'(in_data.seg_b_start_x);
    g1_nxt.db[1] = cpss_pkg::dif_t'(in_data.seg_b_end_y) - cpss_pkg::dif_t'(in_data.seg_b_start_y);
    g1_nxt.db[2] = cpss_pkg::dif_t'(in_data.seg_b_end_z) - cpss_pkg::dif_t'(in_data.seg_b_start_z);
    for (int i = 0; i < 3; i++) begin
      rr1_nxt[i] = cpss_pkg::dif_t'(g1_nxt.pa[i]) - cpss_pkg::dif_t'(g1_nxt.pb[i]);
    end
  end

  // stage 2: per-axis products
  logic v2_r;
  cpss_pkg::geo_t g2_r;
  cpss_pkg::prd_t [2:0] paa_r, pee_r, pbb_r, pcc_r, pff_r;
  cpss_pkg::prd_t [2:0] paa_nxt, pee_nxt, pbb_nxt, pcc_nxt, pff_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      paa_nxt[i] = cpss_pkg::prd_t'(g1_r.da[i]) * cpss_pkg::prd_t'(g1_r.da[i]);
      pee_nxt[i] = cpss_pkg::prd_t'(g1_r.db[i]) * cpss_pkg::prd_t'(g1_r.db[i]);
      pbb_nxt[i] = cpss_pkg::prd_t'(g1_r.da[i]) * cpss_pkg::prd_t'(g1_r.db[i]);
      pcc_nxt[i] = cpss_pkg::prd_t'(g1_r.da[i]) * cpss_pkg::prd_t'(rr1_r[i]);
      pff_nxt[i] = cpss_pkg::prd_t'(g1_r.db[i]) * cpss_pkg::prd_t'(rr1_r[i]);
    end
  end

  // stage 3: dot products and degenerate flags
  logic v3_r;
  cpss_pkg::d1p_t p3_r, p3_nxt;

  function automatic cpss_pkg::dot_t sum3(input cpss_pkg::prd_t [2:0] x);
    return cpss_pkg::dot_t'(x[0]) + cpss_pkg::dot_t'(x[1]) + cpss_pkg::dot_t'(x[2]);
  endfunction

  always_comb begin
    p3_nxt.d.a   = sum3(paa_r);
    p3_nxt.d.e   = sum3(pee_r);
    p3_nxt.d.b   = sum3(pbb_r);
    p3_nxt.d.c   = sum3(pcc_r);
    p3_nxt.d.f   = sum3(pff_r);
    p3_nxt.a_deg = p3_nxt.d.a <= cpss_pkg::dot_t'(thr_r);
    p3_nxt.e_deg = p3_nxt.d.e <= cpss_pkg::dot_t'(thr_r);
    p3_nxt.g     = g2_r;
  end

  // stage 4: partial products; stage 5: wide products; stage 6: numerator, denominator
  logic v4_r, v5_r, v6_r;
  cpss_pkg::d1p_t p4_r, p5_r, p6_r;
  cpss_pkg::pp_t ae4_r, bb4_r, bf4_r, ce4_r;
  cpss_pkg::wide_t ae5_r, bb5_r, bf5_r, ce5_r;
  cpss_pkg::wide_t num6_r, den6_r;

  // first divider: unclamped s
  logic v7_in;
  cpss_pkg::prm_t q1;
  logic [$bits(cpss_pkg::d1p_t)-1:0] p7_raw;

  cpss_div #(
    .W  (cpss_pkg::WIDE),
    .PW ($bits(cpss_pkg::d1p_t))
  ) u_div_s (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v6_r),
    .num     (num6_r),
    .den     (den6_r),
    .pay_in  (p6_r),
    .out_vld (v7_in),
    .quo     (q1),
    .pay_out (p7_raw)
  );

  // stage 7: t numerator from s
  logic v7_r;
  cpss_pkg::d1p_t p7_r, p7_nxt;
  cpss_pkg::prm_t s7_r;
  cpss_pkg::mid_t tn7_r, tn7_nxt;

  always_comb begin
    p7_nxt  = cpss_pkg::d1p_t'(p7_raw);
    tn7_nxt = cpss_pkg::mid_t'(p7_nxt.d.b) * cpss_pkg::mid_t'($signed({1'b0, q1}))
              + (cpss_pkg::mid_t'(p7_nxt.d.f) <<< QW);
  end

  // pick the second quotient
  cpss_pkg::mid_t num8, den8, ep8;
  cpss_pkg::d2p_t p8;

  always_comb begin
    ep8     = cpss_pkg::mid_t'(p7_r.d.e) <<< QW;
    p8.g    = p7_r.g;
    p8.fixed = '0;
    p8.to_t  = 1'b1;
    num8     = '0;
    den8     = '0;
    if (p7_r.a_deg && p7_r.e_deg) begin
      num8 = '0;
    end else if (p7_r.a_deg) begin
      num8 = cpss_pkg::mid_t'(p7_r.d.f);
      den8 = cpss_pkg::mid_t'(p7_r.d.e);
    end else if (p7_r.e_deg || tn7_r < 0) begin
      num8    = -cpss_pkg::mid_t'(p7_r.d.c);
      den8    = cpss_pkg::mid_t'(p7_r.d.a);
      p8.to_t = 1'b0;
    end else if (tn7_r > ep8) begin
      num8     = cpss_pkg::mid_t'(p7_r.d.b) - cpss_pkg::mid_t'(p7_r.d.c);
      den8     = cpss_pkg::mid_t'(p7_r.d.a);
      p8.fixed = cpss_pkg::ONE;
      p8.to_t  = 1'b0;
    end else begin
      num8     = tn7_r;
      den8     = ep8;
      p8.fixed = s7_r;
    end
  end

  logic v9_in;
  cpss_pkg::prm_t q2;
  logic [$bits(cpss_pkg::d2p_t)-1:0] p9_raw;

  cpss_div #(
    .W  (cpss_pkg::MID),
    .PW ($bits(cpss_pkg::d2p_t))
  ) u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v7_r),
    .num     (num8),
    .den     (den8),
    .pay_in  (p8),
    .out_vld (v9_in),
    .quo     (q2),
    .pay_out (p9_raw)
  );

  // stage 9: final parameters and scaled directions
  logic v9_r;
  cpss_pkg::d2p_t p9;
  cpss_pkg::prm_t s9_nxt, t9_nxt, s9_r, t9_r;
  cpss_pkg::geo_t g9_r;
  cpss_pkg::alw_t [2:0] pra9_r, prb9_r, pra9_nxt, prb9_nxt;

  always_comb begin
    p9     = cpss_pkg::d2p_t'(p9_raw);
    s9_nxt = p9.to_t ? p9.fixed : q2;
    t9_nxt = p9.to_t ? q2 : p9.fixed;
    for (int i = 0; i < 3; i++) begin
      pra9_nxt[i] = cpss_pkg::alw_t'(p9.g.da[i]) * cpss_pkg::alw_t'($signed({1'b0, s9_nxt}));
      prb9_nxt[i] = cpss_pkg::alw_t'(p9.g.db[i]) * cpss_pkg::alw_t'($signed({1'b0, t9_nxt}));
    end
  end

  // stage 10: near points, rounded half up
  logic v10_r;
  cpss_pkg::prm_t s10_r, t10_r;
  cpss_pkg::nw_t [2:0] na10_r, nb10_r, na10_nxt, nb10_nxt;
  localparam cpss_pkg::alw_t RND = cpss_pkg::alw_t'(1 << (QW - 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      na10_nxt[i] = cpss_pkg::nw_t'(g9_r.pa[i]) + cpss_pkg::nw_t'((pra9_r[i] + RND) >>> QW);
      nb10_nxt[i] = cpss_pkg::nw_t'(g9_r.pb[i]) + cpss_pkg::nw_t'((prb9_r[i] + RND) >>> QW);
    end
  end

  // stage 11: squared axis distances
  logic v11_r;
  cpss_pkg::prm_t s11_r, t11_r;
  cpss_pkg::nw_t [2:0] na11_r, nb11_r;
  cpss_pkg::sq_t [2:0] sq11_r, sq11_nxt;
  cpss_pkg::dfw_t [2:0] dif11;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif11[i]    = cpss_pkg::dfw_t'(na10_r[i]) - cpss_pkg::dfw_t'(nb10_r[i]);
      sq11_nxt[i] = cpss_pkg::sq_t'(dif11[i]) * cpss_pkg::sq_t'(dif11[i]);
    end
  end

  // output stage: distance sum with saturation
  cpss_pkg::sum_t sum12;
  cpss_pkg::out_t out_nxt;

  always_comb begin
    sum12 = cpss_pkg::sum_t'(sq11_r[0]) + cpss_pkg::sum_t'(sq11_r[1])
            + cpss_pkg::sum_t'(sq11_r[2]);
    out_nxt.param_a  = s11_r;
    out_nxt.param_b  = t11_r;
    out_nxt.near_a_x = na11_r[0][cpss_pkg::CW-1:0];
    out_nxt.near_a_y = na11_r[1][cpss_pkg::CW-1:0];
    out_nxt.near_a_z = na11_r[2][cpss_pkg::CW-1:0];
    out_nxt.near_b_x = nb11_r[0][cpss_pkg::CW-1:0];
    out_nxt.near_b_y = nb11_r[1][cpss_pkg::CW-1:0];
    out_nxt.near_b_z = nb11_r[2][cpss_pkg::CW-1:0];
    out_nxt.dist_sq  = (sum12 > cpss_pkg::sum_t'(cpss_pkg::DMAX)) ? cpss_pkg::DMAX
                                                                    : sum12[cpss_pkg::DISTW-1:0];
  end

  // valid chain: advance together, hold on output stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v7_in;
      v9_r        <= v9_in;
      v10_r       <= v9_r;
      v11_r       <= v10_r;
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r   <= g1_nxt;
      rr1_r  <= rr1_nxt;
      g2_r   <= g1_r;
      paa_r  <= paa_nxt;
      pee_r  <= pee_nxt;
      pbb_r  <= pbb_nxt;
      pcc_r  <= pcc_nxt;
      pff_r  <= pff_nxt;
      p3_r   <= p3_nxt;
      p4_r   <= p3_r;
      ae4_r  <= cpss_pkg::pp_mul(p3_r.d.a, p3_r.d.e);
      bb4_r  <= cpss_pkg::pp_mul(p3_r.d.b, p3_r.d.b);
      bf4_r  <= cpss_pkg::pp_mul(p3_r.d.b, p3_r.d.f);
      ce4_r  <= cpss_pkg::pp_mul(p3_r.d.c, p3_r.d.e);
      p5_r   <= p4_r;
      ae5_r  <= cpss_pkg::pp_sum(ae4_r);
      bb5_r  <= cpss_pkg::pp_sum(bb4_r);
      bf5_r  <= cpss_pkg::pp_sum(bf4_r);
      ce5_r  <= cpss_pkg::pp_sum(ce4_r);
      p6_r   <= p5_r;
      num6_r <= bf5_r - ce5_r;
      den6_r <= ae5_r - bb5_r;
      p7_r   <= p7_nxt;
      s7_r   <= q1;
      tn7_r  <= tn7_nxt;
      s9_r   <= s9_nxt;
      t9_r   <= t9_nxt;
      g9_r   <= p9.g;
      pra9_r <= pra9_nxt;
      prb9_r <= prb9_nxt;
      s10_r  <= s9_r;
      t10_r  <= t9_r;
      na10_r <= na10_nxt;
      nb10_r <= nb10_nxt;
      s11_r  <= s10_r;
      t11_r  <= t10_r;
      na11_r <= na10_r;
      nb11_r <= nb10_r;
      sq11_r <= sq11_nxt;
      out_r  <= out_nxt;
    end
  end

  // parameters are saturated quotients
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.param_a <= cpss_pkg::ONE && out_r.param_b <= cpss_pkg::ONE))
    else $error("parameter above one");

  // a held output freezes every stage
  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v1_r) && $stable(v7_r) && $stable(v11_r)))
    else $error("pipeline moved while output stalled");

  // near points stay on their segments, so the distance never gets near the top
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.dist_sq[cpss_pkg::DISTW-1:cpss_pkg::DISTW-2] == 2'b00)
    else $error("distance out of range");

endmodule
`default_nettype wire
